// ----- rtl/btl_pkg.sv -----
// Shared types and constants for the bilinear table interpolator.
`default_nettype none
package btl_pkg;

  localparam int RowMax   = 64;
  localparam int ColMax   = 64;
  localparam int IdxW     = 6;
  localparam int CntW     = 7;
  localparam int DataW    = 32;
  localparam int FracW    = 17;
  localparam int QueueDepth = 2;

  localparam logic [FracW-1:0] FracOne = 17'h10000;

  typedef enum logic [1:0] {
    REQ_LOAD_ROW  = 2'd0,
    REQ_LOAD_COL  = 2'd1,
    REQ_LOAD_GRID = 2'd2,
    REQ_QUERY     = 2'd3
  } req_t;

  typedef enum logic {
    REG_ROW_USED = 1'b0,
    REG_COL_USED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    req_t                     req;
    logic [IdxW-1:0]          row_index;
    logic [IdxW-1:0]          col_index;
    logic signed [DataW-1:0]  load_value;
    logic signed [DataW-1:0]  query_row;
    logic signed [DataW-1:0]  query_col;
  } item_t;

  typedef struct packed {
    logic valid;
    logic is_query;
  } queue_status_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

  typedef enum logic [4:0] {
    B_IDLE, B_RD_FIRST, B_RD_LAST, B_CLAMP, B_S_ADDR, B_S_CMP, B_FIX,
    B_P0, B_P1, B_DIVSET, B_DIV,
    B_G0, B_G1, B_G2, B_G3, B_G4, B_G5, B_G6, B_G7, B_G8, B_OUT
  } bstate_t;

  // Clamp a used-count register to the legal 2..limit range.
  function automatic logic [CntW-1:0] used_count(input logic [CntW-1:0] v,
                                                 input logic [CntW-1:0] lim);
    logic [CntW-1:0] r;
    r = v;
    if (v < CntW'(2)) r = CntW'(2);
    else if (v > lim) r = lim;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bilinear_table_interpolator_unit.sv -----
// Top level of the bilinear table interpolator: configuration port, front end and engine.
`default_nettype none
// Loads (row breakpoint, column breakpoint, grid value) are written by the idle engine and
// produce no result. For a query, the cell search reads one breakpoint per axis in each
// address and compare step from the breakpoint memories, the fraction divider produces one
// bit per cycle, 16 bits in all, and the four grid corners are read one per cycle from the
// single-port grid memory into one shared multiplier.
// A two-entry queue in front of the engine accepts further transfers while a query runs,
// and the result register frees the engine once its value is taken.
module bilinear_table_interpolator_unit
  import btl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        req_type,
  input  wire logic [IdxW-1:0]   row_index,
  input  wire logic [IdxW-1:0]   col_index,
  input  wire logic signed [DataW-1:0] load_value,
  input  wire logic signed [DataW-1:0] query_row,
  input  wire logic signed [DataW-1:0] query_col,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [DataW-1:0] interp_value
);

  logic [CntW-1:0] row_points_used;
  logic [CntW-1:0] col_points_used;
  item_t           in_item;
  item_t           q_item;
  queue_status_t   q_status;
  back_status_t    b_status;
  logic            q_pop;
  reg_idx_t        ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[2]);
  assign prdata = (ridx == REG_COL_USED) ? 32'(col_points_used) : 32'(row_points_used);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_points_used <= CntW'(2);
      col_points_used <= CntW'(2);
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_ROW_USED: row_points_used <= pwdata[CntW-1:0];
        REG_COL_USED: col_points_used <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.req        = req_t'(req_type);
  assign in_item.row_index  = row_index;
  assign in_item.col_index  = col_index;
  assign in_item.load_value = load_value;
  assign in_item.query_row  = query_row;
  assign in_item.query_col  = query_col;

  btl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_status (q_status),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  btl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .row_used     (row_points_used),
    .col_used     (col_points_used),
    .status       (b_status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .interp_value (interp_value)
  );

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("outputs not quiet after reset");

  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_status.busy))
    else $error("result appeared without a query in the engine");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !b_status.busy)
    else $error("queue popped while the engine was busy");

endmodule
`default_nettype wire

// ----- rtl/btl_front.sv -----
// Front end: accepts request transfers, tags queries and queues them for the engine.
`default_nettype none
module btl_front
  import btl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire item_t   in_item,
  output queue_status_t q_status,
  output item_t        q_item,
  input  wire logic    q_pop
);

  item_t      slots [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall = (count == 2'(QueueDepth));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != 2'd0);

  assign q_item            = slots[rd_ptr];
  assign q_status.valid    = (count != 2'd0);
  assign q_status.is_query = (slots[rd_ptr].req == REQ_QUERY);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/btl_back.sv -----
// Back end: table memories, per-axis search and divide, bilinear blend, result register.
`default_nettype none
module btl_back
  import btl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire queue_status_t    q_status,
  input  wire item_t            q_item,
  output logic                  q_pop,
  input  wire logic [CntW-1:0]  row_used,
  input  wire logic [CntW-1:0]  col_used,
  output back_status_t          status,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic signed [DataW-1:0] interp_value
);

  logic signed [DataW-1:0] bp_mem0 [RowMax];
  logic signed [DataW-1:0] bp_mem1 [ColMax];
  logic signed [DataW-1:0] grid    [RowMax*ColMax];

  bstate_t state, state_next;

  logic [IdxW-1:0]         bp_addr [2];
  logic signed [DataW-1:0] bp_rd   [2];
  logic [2*IdxW-1:0]       g_addr;
  logic signed [DataW-1:0] g_rd;

  logic [CntW-1:0]         n     [2];
  logic [CntW-1:0]         nmax;
  logic signed [DataW-1:0] qx    [2];
  logic signed [DataW-1:0] first [2];
  logic signed [DataW-1:0] cx    [2];
  logic                    found [2];
  logic [CntW-1:0]         hit   [2];
  logic [IdxW-1:0]         lo    [2];
  logic [IdxW-1:0]         hi    [2];
  logic signed [DataW-1:0] p0    [2];
  logic [FracW-1:0]        frac  [2];
  logic [33:0]             rem   [2];
  logic [32:0]             aden  [2];
  logic                    dodiv [2];
  logic [CntW-1:0]         k;
  logic [3:0]              dcnt;

  logic signed [48:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [66:0] prod;
  logic signed [48:0] b0;
  logic signed [48:0] b1;
  logic signed [65:0] acc;
  logic signed [65:0] biased;
  logic signed [33:0] rounded;
  logic signed [DataW-1:0] sat;
  logic               out_free;

  assign status.busy = (state != B_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign nmax        = (n[0] > n[1]) ? n[0] : n[1];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:     if (q_status.valid && q_status.is_query) state_next = B_RD_FIRST;
      B_RD_FIRST: state_next = B_RD_LAST;
      B_RD_LAST:  state_next = B_CLAMP;
      B_CLAMP:    state_next = B_S_ADDR;
      B_S_ADDR:   state_next = B_S_CMP;
      B_S_CMP:    state_next = (k + CntW'(1) == nmax) ? B_FIX : B_S_ADDR;
      B_FIX:      state_next = B_P0;
      B_P0:       state_next = B_P1;
      B_P1:       state_next = B_DIVSET;
      B_DIVSET:   state_next = B_DIV;
      B_DIV:      if (dcnt == 4'd15) state_next = B_G0;
      B_G0:       state_next = B_G1;
      B_G1:       state_next = B_G2;
      B_G2:       state_next = B_G3;
      B_G3:       state_next = B_G4;
      B_G4:       state_next = B_G5;
      B_G5:       state_next = B_G6;
      B_G6:       state_next = B_G7;
      B_G7:       state_next = B_G8;
      B_G8:       state_next = B_OUT;
      B_OUT:      if (out_free) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  // Outputs: memory addresses, queue pop, multiplier operands
  always_comb begin
    q_pop = 1'b0;
    for (int a = 0; a < 2; a++) bp_addr[a] = '0;
    g_addr = {lo[0], lo[1]};
    mul_a  = 49'(g_rd);
    mul_b  = 18'($signed({1'b0, FracOne - frac[1]}));
    unique case (state)
      B_IDLE: q_pop = q_status.valid;
      B_RD_LAST: for (int a = 0; a < 2; a++) bp_addr[a] = IdxW'(n[a] - CntW'(1));
      B_S_ADDR:  for (int a = 0; a < 2; a++) bp_addr[a] = k[IdxW-1:0];
      B_P0:      for (int a = 0; a < 2; a++) bp_addr[a] = lo[a];
      B_P1:      for (int a = 0; a < 2; a++) bp_addr[a] = hi[a];
      B_G0: g_addr = {lo[0], lo[1]};
      B_G1: g_addr = {lo[0], hi[1]};
      B_G2: begin
        g_addr = {hi[0], lo[1]};
        mul_b  = 18'($signed({1'b0, frac[1]}));
      end
      B_G3: g_addr = {hi[0], hi[1]};
      B_G4: mul_b = 18'($signed({1'b0, frac[1]}));
      B_G6: begin
        mul_a = b0;
        mul_b = 18'($signed({1'b0, FracOne - frac[0]}));
      end
      B_G7: begin
        mul_a = b1;
        mul_b = 18'($signed({1'b0, frac[0]}));
      end
      default: ;
    endcase
  end

  // Table memories, registered reads
  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_status.valid) begin
      unique case (q_item.req)
        REQ_LOAD_ROW:  bp_mem0[q_item.row_index] <= q_item.load_value;
        REQ_LOAD_COL:  bp_mem1[q_item.col_index] <= q_item.load_value;
        REQ_LOAD_GRID: grid[{q_item.row_index, q_item.col_index}] <= q_item.load_value;
        default: ;
      endcase
    end
    bp_rd[0] <= bp_mem0[bp_addr[0]];
    bp_rd[1] <= bp_mem1[bp_addr[1]];
    g_rd     <= grid[g_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  assign biased  = acc + 66'sh80000000;
  assign rounded = 34'(biased >>> 32);
  always_comb begin
    if (rounded > 34'sh07FFFFFFF)       sat = 32'sh7FFFFFFF;
    else if (rounded < -34'sh080000000) sat = 32'sh80000000;
    else                                sat = rounded[DataW-1:0];
  end

  // Datapath
  always_ff @(posedge clk) begin
    logic signed [32:0] num;
    logic signed [32:0] den;
    logic [32:0]        anum;
    logic [32:0]        adn;
    logic signed [DataW-1:0] c;
    logic [CntW-1:0]    i;
    logic [33:0]        r2;
    prod <= mul_a * mul_b;
    unique case (state)
      B_IDLE: begin
        n[0]  <= used_count(row_used, CntW'(RowMax));
        n[1]  <= used_count(col_used, CntW'(ColMax));
        qx[0] <= q_item.query_row;
        qx[1] <= q_item.query_col;
      end
      B_RD_LAST: begin
        for (int a = 0; a < 2; a++) first[a] <= bp_rd[a];
      end
      B_CLAMP: begin
        for (int a = 0; a < 2; a++) begin
          c = (qx[a] < bp_rd[a]) ? qx[a] : bp_rd[a];
          if (c < first[a]) c = first[a];
          cx[a]    <= c;
          found[a] <= 1'b0;
          hit[a]   <= n[a];
        end
        k <= '0;
      end
      B_S_CMP: begin
        for (int a = 0; a < 2; a++) begin
          if (!found[a] && k < n[a] && bp_rd[a] > cx[a]) begin
            found[a] <= 1'b1;
            hit[a]   <= k;
          end
        end
        k <= k + CntW'(1);
      end
      B_FIX: begin
        for (int a = 0; a < 2; a++) begin
          i = hit[a];
          if (i == CntW'(0)) i = CntW'(1);
          if (i >= n[a]) i = n[a] - CntW'(1);
          hi[a] <= i[IdxW-1:0];
          lo[a] <= IdxW'(i - CntW'(1));
        end
      end
      B_P1: begin
        for (int a = 0; a < 2; a++) p0[a] <= bp_rd[a];
      end
      B_DIVSET: begin
        dcnt <= '0;
        for (int a = 0; a < 2; a++) begin
          num  = 33'(cx[a]) - 33'(p0[a]);
          den  = 33'(bp_rd[a]) - 33'(p0[a]);
          anum = num[32] ? 33'(-num) : 33'(num);
          adn  = den[32] ? 33'(-den) : 33'(den);
          aden[a]  <= adn;
          rem[a]   <= 34'(anum);
          dodiv[a] <= 1'b0;
          frac[a]  <= '0;
          if (den == 33'sd0 || (num[32] != den[32] && num != 33'sd0)) begin
            frac[a] <= '0;
          end else if (anum >= adn) begin
            frac[a] <= FracOne;
          end else begin
            dodiv[a] <= 1'b1;
          end
        end
      end
      B_DIV: begin
        dcnt <= dcnt + 4'd1;
        for (int a = 0; a < 2; a++) begin
          if (dodiv[a]) begin
            r2 = {rem[a][32:0], 1'b0};
            if (r2 >= 34'(aden[a])) begin
              rem[a]  <= r2 - 34'(aden[a]);
              frac[a] <= {frac[a][FracW-2:0], 1'b1};
            end else begin
              rem[a]  <= r2;
              frac[a] <= {frac[a][FracW-2:0], 1'b0};
            end
          end
        end
      end
      B_G2: b0  <= 49'(prod);
      B_G3: b0  <= b0 + 49'(prod);
      B_G4: b1  <= 49'(prod);
      B_G5: b1  <= b1 + 49'(prod);
      B_G7: acc <= 66'(prod);
      B_G8: acc <= acc + 66'(prod);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) interp_value <= sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
